// ===== rtl/tdpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared constants, types and helpers for the tail-drop packet buffer.
// ----------------------------------------------------------------------------
package tdpb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int OCC_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int CFG_W  = 7;
    localparam int ARR_W  = 31;
    localparam int DUR_W  = 16;
    localparam int TIME_W = 32;

    localparam logic [CFG_W-1:0] BUFFER_SIZE_RESET = 7'd64;

    localparam int ADDR_W = 3;
    localparam logic REG_BUFFER_SIZE = 1'b0;

    typedef struct packed {
        logic load;
        logic pop;
        logic push;
        logic drop;
    } dp_cmd_t;

    typedef struct packed {
        logic             head_expired;
        logic             full;
        logic [OCC_W-1:0] occ;
    } dp_stat_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(BUFFER_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/tail_drop_packet_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer
// Single-server FIFO with tail drop: reports start tick or drop per packet.
//
//   Port group   Handshake            Payload
//   ----------   ------------------   ------------------------------------
//   input        start & !busy        arrival_time[30:0], duration[15:0]
//   result       done (1 cycle)       dropped, start_time[31:0]
//   config       APB write, pready=1  buffer_size[6:0] at byte address 0
//
// Each packet is loaded, finished packets are retired from the head one per
// cycle through the FIFO RAM read port, then it is queued or dropped; done follows.
// Reset: queue empty, buffer_size = 64; FIFO RAM is not cleared.
// The result receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module tail_drop_packet_buffer
    import tdpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ARR_W-1:0]  arrival_time,
    input  logic [DUR_W-1:0]  duration,
    output logic              done,
    output logic              dropped,
    output logic [TIME_W-1:0] start_time,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CFG_W-1:0] buffer_size_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_BUFFER_SIZE))
        begin
            buffer_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? 32'(buffer_size_reg) : '0;

    tdpb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tdpb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .arrival_time (arrival_time),
        .duration     (duration),
        .buffer_size  (buffer_size_reg),
        .stat         (stat),
        .done         (done),
        .dropped      (dropped),
        .start_time   (start_time)
    );

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter processing");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still processing");

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stat.occ) <= 32'(BUFFER_DEPTH))
        else $error("occupancy exceeds buffer depth");

    a_drop_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (start_time == '0))
        else $error("dropped transaction reports nonzero start time");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results for one transaction");

endmodule

// ===== rtl/tdpb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tdpb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_ctrl
// Sequencer: accepts a packet, drains expired entries, then drops or queues.
// ----------------------------------------------------------------------------
module tdpb_ctrl
    import tdpb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.head_expired)
                begin
                    cmd.pop = 1'b1;
                end
                else if (stat.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_CHECK);

endmodule

// ===== rtl/tdpb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_datapath
// Finish-time FIFO, pointers, occupancy, start/finish arithmetic, result regs.
// ----------------------------------------------------------------------------
module tdpb_datapath
    import tdpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [ARR_W-1:0]  arrival_time,
    input  logic [DUR_W-1:0]  duration,
    input  logic [CFG_W-1:0]  buffer_size,
    output dp_stat_t          stat,
    output logic              done,
    output logic              dropped,
    output logic [TIME_W-1:0] start_time
);

    logic [PTR_W-1:0]  head_reg,        head_next;
    logic [PTR_W-1:0]  tail_reg,        tail_next;
    logic [OCC_W-1:0]  occ_reg,         occ_next;
    logic [ARR_W-1:0]  arrival_reg;
    logic [TIME_W-1:0] start_cand_reg;
    logic [TIME_W-1:0] finish_reg;
    logic [TIME_W-1:0] last_finish_reg;
    logic              done_reg;
    logic              dropped_reg;
    logic [TIME_W-1:0] start_time_reg;

    logic [TIME_W-1:0] arrival_ext;
    logic [TIME_W-1:0] start_cand;
    logic [TIME_W:0]   finish_sum;
    logic [TIME_W-1:0] finish_sat;
    logic [31:0]       limit_wide;
    logic [OCC_W-1:0]  limit;
    logic [PTR_W-1:0]  raddr;
    logic [TIME_W-1:0] head_finish;

    assign arrival_ext = {1'b0, arrival_time};
    assign start_cand  = ((occ_reg != '0) && (last_finish_reg > arrival_ext))
                         ? last_finish_reg : arrival_ext;
    assign finish_sum  = {1'b0, start_cand} + (TIME_W + 1)'(duration);
    assign finish_sat  = finish_sum[TIME_W] ? '1 : finish_sum[TIME_W-1:0];

    always_comb
    begin
        if (buffer_size == '0)
            limit_wide = 32'd1;
        else if (32'(buffer_size) > 32'(BUFFER_DEPTH))
            limit_wide = 32'(BUFFER_DEPTH);
        else
            limit_wide = 32'(buffer_size);
    end
    assign limit = limit_wide[OCC_W-1:0];

    assign raddr = cmd.pop ? next_ptr(head_reg) : head_reg;

    tdpb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_reg),
        .wdata (finish_reg),
        .raddr (raddr),
        .rdata (head_finish)
    );

    assign stat.head_expired = (occ_reg != '0) && (head_finish <= {1'b0, arrival_reg});
    assign stat.full         = (occ_reg >= limit);
    assign stat.occ          = occ_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (cmd.pop)
        begin
            head_next = next_ptr(head_reg);
            occ_next  = occ_reg - OCC_W'(1);
        end
        else if (cmd.push)
        begin
            tail_next = next_ptr(tail_reg);
            occ_next  = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            done_reg <= cmd.push | cmd.drop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arrival_reg    <= arrival_time;
            start_cand_reg <= start_cand;
            finish_reg     <= finish_sat;
        end
        if (cmd.push)
        begin
            last_finish_reg <= finish_reg;
        end
        if (cmd.push | cmd.drop)
        begin
            dropped_reg    <= cmd.drop;
            start_time_reg <= cmd.drop ? '0 : start_cand_reg;
        end
    end

    assign done       = done_reg;
    assign dropped    = dropped_reg;
    assign start_time = start_time_reg;

endmodule
